[design/abs_pkg.sv]
// Package for the alternating-bit sender: command codes, widths, register map
// and the control/status structs shared by the top level and its timer.
// No dependencies.
`default_nettype none

package abs_pkg;

    localparam int SUM_W   = 13;
    localparam int TIMER_W = 16;
    localparam int BYTE_W  = 8;

    // Register map (register index within the APB window)
    localparam logic REG_TIMEOUT = 1'b0;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd20;

    typedef enum logic [1:0] {
        CMD_MSG  = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef struct packed {
        logic start;
        logic stop;
        logic tick;
    } timer_ctl_t;

    typedef struct packed {
        logic running;
        logic at_last;
    } timer_sts_t;

endpackage : abs_pkg

`default_nettype wire

[design/abs_timer.sv]
// Retransmission timer for the alternating-bit sender.
// Depends on abs_pkg (timer_ctl_t, timer_sts_t, TIMER_W).
`default_nettype none

module abs_timer
    import abs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [TIMER_W-1:0] timeout,
    input  wire timer_ctl_t         ctl,
    output timer_sts_t              sts
);

    logic               running_reg;
    logic               running_next;
    logic [TIMER_W-1:0] count_reg;
    logic [TIMER_W-1:0] count_next;

    always_comb
    begin
        running_next = running_reg;
        count_next   = count_reg;
        if (ctl.start)
        begin
            // a zero timeout acts as one tick
            count_next   = (timeout == '0) ? TIMER_W'(1) : timeout;
            running_next = 1'b1;
        end
        else if (ctl.stop)
        begin
            count_next   = '0;
            running_next = 1'b0;
        end
        else if (ctl.tick && running_reg && count_reg > TIMER_W'(1))
        begin
            count_next = count_reg - TIMER_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            running_reg <= running_next;
            count_reg   <= count_next;
        end
    end

    assign sts.running = running_reg;
    assign sts.at_last = (count_reg <= TIMER_W'(1));

endmodule : abs_timer

`default_nettype wire

[design/alternating_bit_sender.sv]
// Alternating-bit protocol sender: message queue, ack checker, resend sequencer.
// Depends on abs_pkg and abs_timer.
// Usage
//   Input channel (in_valid/in_ready): one transaction per command. A message
//   byte is queued into the entry being filled; an ack byte adds to the running
//   ack checksum and, on last_byte, is judged against pkt_seq/pkt_ack/
//   pkt_checksum; a timer tick counts down the retransmission timer.
//   Output channel (out_valid/out_ready): each send of the head entry gives
//   PAYLOAD_BYTES transactions, the final one flagged by out_last.
//   APB port: register 0 (byte address 0) is timeout_ticks, reset value 20.
// Timing
//   A message or ack byte that completes nothing leaves the sender idle. A short message
//   pads the entry with zeros, one byte per cycle, then commits it (ST_COMMIT).
//   A send first fetches the entry checksum (ST_LOAD_SUM), then for each byte
//   reads it (ST_READ) and presents it (ST_PRESENT) until out_ready takes it.
//   in_ready is low while padding, committing or sending.
// Reset: rst_n clears queue pointers, counts, sequence bit, timer and drop flag;
//   the payload and checksum memories are left as they are, since every entry
//   is written in full before it is ever read.
// Stalls: while out_ready is low the current output byte is held; nothing moves.
`default_nettype none

module alternating_bit_sender
    import abs_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_BYTES = 20
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic              pkt_seq,
    input  wire logic              pkt_ack,
    input  wire logic [12:0]       pkt_checksum,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   out_seq,
    output logic [12:0]            out_checksum,
    output logic                   out_last,
    output logic                   overflow_seen,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int STORE_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int POS_W  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMMIT,
        ST_LOAD_SUM,
        ST_READ,
        ST_PRESENT
    } state_t;

    // control state
    state_t              state_reg,     state_next;
    logic [IDX_W-1:0]    head_reg,      head_next;
    logic [IDX_W-1:0]    tail_reg,      tail_next;
    logic [ADDR_W-1:0]   head_base_reg, head_base_next;
    logic [ADDR_W-1:0]   tail_base_reg, tail_base_next;
    logic [CNT_W-1:0]    count_reg,     count_next;
    logic [FILL_W-1:0]   fill_reg,      fill_next;
    logic [SUM_W-1:0]    fill_sum_reg,  fill_sum_next;
    logic [SUM_W-1:0]    ack_sum_reg,   ack_sum_next;
    logic                send_bit_reg,  send_bit_next;
    logic                waiting_reg,   waiting_next;
    logic                drop_reg,      drop_next;
    logic                discard_reg,   discard_next;
    logic [POS_W-1:0]    pos_reg,       pos_next;
    logic [SUM_W-1:0]    csum_reg,      csum_next;
    logic [TIMER_W-1:0]  timeout_reg;

    // memories
    logic [BYTE_W-1:0]   pay_mem [STORE_DEPTH];
    logic [SUM_W-1:0]    sum_mem [QUEUE_DEPTH];
    logic [BYTE_W-1:0]   pay_rd_reg;
    logic [SUM_W-1:0]    sum_rd_reg;

    logic                pay_wr_en;
    logic [ADDR_W-1:0]   pay_wr_addr;
    logic [BYTE_W-1:0]   pay_wr_data;
    logic                pay_rd_en;
    logic [ADDR_W-1:0]   pay_rd_addr;
    logic                sum_wr_en;
    logic                sum_rd_en;

    timer_ctl_t          tmr_ctl;
    timer_sts_t          tmr_sts;

    // datapath helpers
    logic                in_fire;
    logic                start_drop;
    logic                disc_eff;
    logic [FILL_W-1:0]   fill_inc;
    logic [SUM_W-1:0]    ack_new;
    logic [SUM_W-1:0]    ack_chk;
    logic                ack_good;
    logic [CNT_W-1:0]    count_after;
    logic                cfg_wr;

    assign in_fire = in_valid && in_ready;

    abs_timer u_timer (
        .clk     (clk),
        .rst_n   (rst_n),
        .timeout (timeout_reg),
        .ctl     (tmr_ctl),
        .sts     (tmr_sts)
    );

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TIMEOUT)
        begin
            prdata = {{(32 - TIMER_W){1'b0}}, timeout_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= pwdata[TIMER_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Shared arithmetic terms
    // ---------------------------------------------------------------
    // A message is dropped whole when the queue is full at its first byte.
    assign start_drop = (fill_reg == '0) && !discard_reg
                        && (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign disc_eff   = discard_reg || start_drop;
    assign fill_inc   = fill_reg + FILL_W'(1);

    assign ack_new  = ack_sum_reg + SUM_W'(data_byte);
    assign ack_chk  = SUM_W'(pkt_seq) + SUM_W'(pkt_ack) + ack_new;
    assign ack_good = (pkt_ack == send_bit_reg) && (ack_chk == pkt_checksum);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        head_base_next = head_base_reg;
        tail_base_next = tail_base_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        fill_sum_next  = fill_sum_reg;
        ack_sum_next   = ack_sum_reg;
        send_bit_next  = send_bit_reg;
        waiting_next   = waiting_reg;
        drop_next      = drop_reg;
        discard_next   = discard_reg;
        pos_next       = pos_reg;
        csum_next      = csum_reg;
        count_after    = count_reg;

        pay_wr_en   = 1'b0;
        pay_wr_addr = tail_base_reg + ADDR_W'(fill_reg);
        pay_wr_data = data_byte;
        pay_rd_en   = 1'b0;
        pay_rd_addr = head_base_reg + ADDR_W'(pos_reg);
        sum_wr_en   = 1'b0;
        sum_rd_en   = 1'b0;
        tmr_ctl     = '0;

        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_PRESENT);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd_t'(command))
                        CMD_MSG:
                        begin
                            if (start_drop)
                            begin
                                drop_next = 1'b1;
                            end
                            if (!disc_eff)
                            begin
                                pay_wr_en     = 1'b1;
                                fill_sum_next = ((fill_reg == '0) ? '0 : fill_sum_reg)
                                                + SUM_W'(data_byte);
                            end
                            if (!last_byte && fill_inc < FILL_W'(PAYLOAD_BYTES))
                            begin
                                fill_next    = fill_inc;
                                discard_next = disc_eff;
                            end
                            else if (disc_eff)
                            begin
                                // end of a dropped message
                                discard_next = 1'b0;
                                fill_next    = '0;
                            end
                            else
                            begin
                                fill_next = fill_inc;
                                state_next = (fill_inc < FILL_W'(PAYLOAD_BYTES))
                                             ? ST_PAD : ST_COMMIT;
                            end
                        end
                        CMD_ACK:
                        begin
                            if (!last_byte)
                            begin
                                ack_sum_next = ack_new;
                            end
                            else
                            begin
                                ack_sum_next = '0;
                                if (ack_good)
                                begin
                                    tmr_ctl.stop  = 1'b1;
                                    waiting_next  = 1'b0;
                                    send_bit_next = !send_bit_reg;
                                    if (count_reg != '0)
                                    begin
                                        head_next = (head_reg == IDX_W'(QUEUE_DEPTH - 1))
                                                    ? '0 : head_reg + IDX_W'(1);
                                        head_base_next = (head_reg == IDX_W'(QUEUE_DEPTH - 1))
                                                    ? '0 : head_base_reg + ADDR_W'(PAYLOAD_BYTES);
                                        count_after = count_reg - CNT_W'(1);
                                        count_next  = count_after;
                                    end
                                end
                                // good ack sends the next entry, bad or stale ack resends
                                if (count_after != '0)
                                begin
                                    state_next = ST_LOAD_SUM;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (tmr_sts.running)
                            begin
                                if (!tmr_sts.at_last)
                                begin
                                    tmr_ctl.tick = 1'b1;
                                end
                                else
                                begin
                                    tmr_ctl.stop = 1'b1;
                                    if (count_reg != '0)
                                    begin
                                        state_next = ST_LOAD_SUM;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PAD:
            begin
                // zero the unused tail of a short entry
                pay_wr_en   = 1'b1;
                pay_wr_data = '0;
                fill_next   = fill_inc;
                if (fill_inc == FILL_W'(PAYLOAD_BYTES))
                begin
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT:
            begin
                sum_wr_en      = 1'b1;
                fill_next      = '0;
                tail_next      = (tail_reg == IDX_W'(QUEUE_DEPTH - 1))
                                 ? '0 : tail_reg + IDX_W'(1);
                tail_base_next = (tail_reg == IDX_W'(QUEUE_DEPTH - 1))
                                 ? '0 : tail_base_reg + ADDR_W'(PAYLOAD_BYTES);
                count_next     = count_reg + CNT_W'(1);
                state_next     = waiting_reg ? ST_IDLE : ST_LOAD_SUM;
            end

            ST_LOAD_SUM:
            begin
                sum_rd_en     = 1'b1;
                pos_next      = '0;
                waiting_next  = 1'b1;
                tmr_ctl.start = 1'b1;
                state_next    = ST_READ;
            end

            ST_READ:
            begin
                pay_rd_en  = 1'b1;
                csum_next  = SUM_W'(send_bit_reg) + sum_rd_reg;
                state_next = ST_PRESENT;
            end

            ST_PRESENT:
            begin
                if (out_ready)
                begin
                    if (pos_reg == POS_W'(PAYLOAD_BYTES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            head_base_reg <= '0;
            tail_base_reg <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            ack_sum_reg   <= '0;
            send_bit_reg  <= 1'b0;
            waiting_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            discard_reg   <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            head_base_reg <= head_base_next;
            tail_base_reg <= tail_base_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            ack_sum_reg   <= ack_sum_next;
            send_bit_reg  <= send_bit_next;
            waiting_reg   <= waiting_next;
            drop_reg      <= drop_next;
            discard_reg   <= discard_next;
            pos_reg       <= pos_next;
        end
    end

    // payload-only registers
    always_ff @(posedge clk)
    begin
        fill_sum_reg <= fill_sum_next;
        csum_reg     <= csum_next;
    end

    // ---------------------------------------------------------------
    // Payload and entry-checksum memories
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pay_wr_en)
        begin
            pay_mem[pay_wr_addr] <= pay_wr_data;
        end
        if (pay_rd_en)
        begin
            pay_rd_reg <= pay_mem[pay_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_wr_en)
        begin
            sum_mem[tail_reg] <= fill_sum_reg;
        end
        if (sum_rd_en)
        begin
            sum_rd_reg <= sum_mem[head_reg];
        end
    end

    // ---------------------------------------------------------------
    // Output payload: held stable while PRESENT waits on out_ready
    // ---------------------------------------------------------------
    assign out_byte      = pay_rd_reg;
    assign out_seq       = send_bit_reg;
    assign out_checksum  = csum_reg;
    assign out_last      = (pos_reg == POS_W'(PAYLOAD_BYTES - 1));
    assign overflow_seen = drop_reg;

endmodule : alternating_bit_sender

`default_nettype wire

[design/abs_checker.sv]
// Port-level checks for the alternating-bit sender, bound to the top level.
// Depends on alternating_bit_sender (bind target) only.
`default_nettype none

module abs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_seq,
    input wire logic       out_last,
    input wire logic       overflow_seen
);

    // no input is taken while a packet is being presented
    a_no_in_during_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("in_ready high while a packet byte is presented");

    // a stalled output byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
        else $error("output transaction changed while stalled");

    // sequence bit is constant within one packet
    a_seq_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=> $stable(out_seq))
        else $error("sequence bit changed inside a packet");

    // drop flag is sticky
    a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen |=> overflow_seen)
        else $error("overflow_seen cleared without reset");

    // reset empties the output side
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid high during reset");

endmodule : abs_checker

bind alternating_bit_sender abs_checker u_abs_checker (.*);

`default_nettype wire
